/* hdl/bst_pkg.sv */
// Shared constants, types and structs of the B-spline segment tessellator.
package bst_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_CNT_W    = 7;
    localparam int STEP_W       = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int K_W          = $clog2(MAX_SEGMENTS);

    localparam int Q_ONE        = 65536;
    localparam int U_W          = 17;
    localparam int U_ACC_W      = 22;
    localparam int WGT_W        = 20;
    localparam int MUL_W        = 22;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ACC_W        = 40;

    localparam int HALF_Q16     = 32768;
    localparam int HALF6        = 196608;
    localparam int DIV_SHIFT    = 17;
    localparam int DIV_OFFSET   = 3 * (1 << DIV_SHIFT);
    localparam int RECIP        = 699051;
    localparam int RECIP_SHIFT  = 21;
    localparam int QUO_W        = 21;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 1'd1;

    localparam logic [SEG_CNT_W-1:0] SEG_RESET  = 7'd50;
    localparam logic [STEP_W-1:0]    STEP_RESET = 16'd1311;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
        logic   span_last;
    } seg_t;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_U2,
        TAG_T2,
        TAG_U3,
        TAG_T3,
        TAG_ACCX,
        TAG_ACCY,
        TAG_QX
    } mul_tag_t;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
        mul_tag_t                tag;
    } mul_req_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        mul_tag_t                 tag;
    } mul_rsp_t;

    typedef struct packed {
        logic   load;
        logic   restart;
        logic   shift;
        point_t pt;
    } win_ctl_t;

endpackage

/* hdl/bst_in_if.sv */
// Control point channel.
interface bst_in_if import bst_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t ctrl_x;
    coord_t ctrl_y;
    logic   curve_start;

    modport source (output valid, ctrl_x, ctrl_y, curve_start, input ready);
    modport sink   (input valid, ctrl_x, ctrl_y, curve_start, output ready);
endinterface

/* hdl/bst_out_if.sv */
// Polyline segment channel.
interface bst_out_if import bst_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
    logic   span_last;

    modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, span_last,
                    input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, span_last,
                    output ready);
endinterface

/* hdl/bspline_segment_tessellator.sv */
// Top level of the uniform cubic B-spline segment tessellator.
// Control points enter on pt (valid/ready); segments leave on seg (valid/ready).
// A write port (cfg_we, cfg_idx, cfg_data) sets segments_per_span (index 0)
// and param_step (index 1); the user must write only while the block is idle,
// which the block does not enforce. The first three points of a curve, and any
// point with curve_start, are stored in the window and produce no segment.
// Each later point closes a span and yields n segments (n = segments_per_span,
// 0 read as 1, capped at 64). Each curve point is computed on the single shared
// multiplier under the sequencer (power terms, eight multiply-accumulates, two
// reciprocal divides); a span evaluates n+1 curve points, the first segment
// appears after the second, and pt.ready stays low for the whole span.
// Segments go through one output register: when the receiver stalls, the
// sequencer finishes the next curve point and then waits for the register.
// Reset (rst_n low, asynchronous) empties the window, idles the sequencer,
// drops seg.valid and restores the register defaults (50 and 1311).
module bspline_segment_tessellator import bst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bst_in_if.sink                pt,
    bst_out_if.source             seg,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SEG_CNT_W-1:0] seg_cnt_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SEG_CNT_W-1:0] n_eff;

    logic                 busy, emit, done, accept, span_go, slot_free;
    logic [1:0]           held;
    point_t [2:0]         win;
    point_t               p4, p_in;
    seg_t                 seg_item;
    seg_t                 out_reg;
    logic                 out_valid_reg;
    win_ctl_t             wctl;
    mul_req_t             req;
    mul_rsp_t             rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_cnt_reg <= SEG_RESET;
            step_reg    <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SEGMENTS: seg_cnt_reg <= cfg_data[SEG_CNT_W-1:0];
                REG_STEP:     step_reg    <= cfg_data[STEP_W-1:0];
                default:      seg_cnt_reg <= seg_cnt_reg;
            endcase
        end
    end

    assign n_eff = (seg_cnt_reg == '0) ? SEG_CNT_W'(1) :
                   (seg_cnt_reg > SEG_CNT_W'(MAX_SEGMENTS)) ? SEG_CNT_W'(MAX_SEGMENTS) :
                   seg_cnt_reg;

    assign pt.ready  = !busy;
    assign accept    = pt.valid && pt.ready;
    assign span_go   = accept && !pt.curve_start && (held == 2'd3);
    assign p_in.x    = pt.ctrl_x;
    assign p_in.y    = pt.ctrl_y;

    assign wctl.load    = accept && !span_go;
    assign wctl.restart = pt.curve_start;
    assign wctl.shift   = done;
    assign wctl.pt      = done ? p4 : p_in;

    bst_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (wctl),
        .win   (win),
        .held  (held)
    );

    bst_mul_unit u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign slot_free = !out_valid_reg || seg.ready;

    bst_eval_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (span_go),
        .p_new     (p_in),
        .win       (win),
        .n_seg     (n_eff),
        .step      (step_reg),
        .req       (req),
        .rsp       (rsp),
        .slot_free (slot_free),
        .busy      (busy),
        .emit      (emit),
        .seg       (seg_item),
        .done      (done),
        .p4        (p4)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (seg.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= seg_item;
        end
    end

    assign seg.valid       = out_valid_reg;
    assign seg.seg_start_x = out_reg.seg_start_x;
    assign seg.seg_start_y = out_reg.seg_start_y;
    assign seg.seg_end_x   = out_reg.seg_end_x;
    assign seg.seg_end_y   = out_reg.seg_end_y;
    assign seg.span_last   = out_reg.span_last;

    a_span_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        span_go |=> !pt.ready)
        else $error("item accepted during span");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("sequencer busy after span end");

endmodule

/* hdl/bst_mul_unit.sv */
// Shared signed multiplier with registered product and tag.
module bst_mul_unit import bst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic signed [PROD_W-1:0] prod_reg;
    mul_tag_t                 tag_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= TAG_NONE;
        end
        else
        begin
            tag_reg <= req.tag;
        end
    end

    assign rsp.prod = prod_reg;
    assign rsp.tag  = tag_reg;

endmodule

/* hdl/bst_window.sv */
// Three-point control window and held-point count.
module bst_window import bst_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  win_ctl_t       ctl,
    output point_t [2:0]   win,
    output logic   [1:0]   held
);

    point_t [2:0] w_reg;
    logic   [1:0] held_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            if (ctl.restart)
            begin
                w_reg[0] <= ctl.pt;
            end
            else
            begin
                w_reg[held_reg] <= ctl.pt;
            end
        end
        else if (ctl.shift)
        begin
            w_reg[0] <= w_reg[1];
            w_reg[1] <= w_reg[2];
            w_reg[2] <= ctl.pt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
        end
        else if (ctl.load)
        begin
            if (ctl.restart)
            begin
                held_reg <= 2'd1;
            end
            else
            begin
                held_reg <= held_reg + 2'd1;
            end
        end
    end

    assign win  = w_reg;
    assign held = held_reg;

    a_shift_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> held_reg == 2'd3)
        else $error("window shift with fewer than three points");

    a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && !ctl.restart) |-> held_reg != 2'd3)
        else $error("point stored into full window");

endmodule

/* hdl/bst_eval_seq.sv */
// Sequencer: evaluates curve points on the shared multiplier and emits segments.
module bst_eval_seq import bst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  point_t               p_new,
    input  point_t [2:0]         win,
    input  logic [SEG_CNT_W-1:0] n_seg,
    input  logic [STEP_W-1:0]    step,
    output mul_req_t             req,
    input  mul_rsp_t             rsp,
    input  logic                 slot_free,
    output logic                 busy,
    output logic                 emit,
    output seg_t                 seg,
    output logic                 done,
    output point_t               p4
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_UU   = 12'b000000000010,
        S_TT   = 12'b000000000100,
        S_U3   = 12'b000000001000,
        S_T3   = 12'b000000010000,
        S_WB   = 12'b000000100000,
        S_WGT  = 12'b000001000000,
        S_MAC  = 12'b000010000000,
        S_DX   = 12'b000100000000,
        S_DY   = 12'b001000000000,
        S_FIN  = 12'b010000000000,
        S_EMIT = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [U_ACC_W-1:0]        u_reg;
    logic [K_W-1:0]            k_reg;
    logic [2:0]                j_reg;
    logic                      first_reg;
    point_t                    p4_reg;
    point_t                    prev_reg;
    point_t                    cur_reg;
    logic [U_W-1:0]            u2_reg, t2_reg, u3_reg, t3_reg;
    logic [3:0][WGT_W-1:0]     w_reg;
    logic signed [ACC_W-1:0]   accx_reg, accy_reg;

    logic [U_W-1:0]            u_c, t_c;
    logic [PROD_W-1:0]         rnd;
    logic [U_W-1:0]            pow_val;
    logic [U_ACC_W-1:0]        w2_full, w3_full;
    point_t                    psel;
    coord_t                    csel;
    logic signed [ACC_W-1:0]   div_src, div_n, div_x;
    logic [QUO_W-1:0]          quo;
    logic signed [QUO_W:0]     q_s;
    coord_t                    q_sat;
    logic                      last;

    assign u_c = (u_reg > U_ACC_W'(Q_ONE)) ? U_W'(Q_ONE) : u_reg[U_W-1:0];
    assign t_c = U_W'(Q_ONE) - u_c;

    assign rnd     = rsp.prod + PROD_W'(HALF_Q16);
    assign pow_val = rnd[16 +: U_W];

    assign w2_full = U_ACC_W'(4 * Q_ONE) + {5'b0, u3_reg} * U_ACC_W'(3)
                   - {5'b0, u2_reg} * U_ACC_W'(6);
    assign w3_full = {5'b0, u2_reg} * U_ACC_W'(3) + {5'b0, u_c} * U_ACC_W'(3)
                   + U_ACC_W'(Q_ONE) - {5'b0, u3_reg} * U_ACC_W'(3);

    always_comb
    begin
        unique case (j_reg[1:0])
            2'd0: psel = win[0];
            2'd1: psel = win[1];
            2'd2: psel = win[2];
            2'd3: psel = p4_reg;
        endcase
        csel = j_reg[2] ? psel.y : psel.x;
    end

    assign div_src = (state_reg == S_DX) ? accx_reg : accy_reg;
    assign div_n   = div_src + ACC_W'(HALF6);
    assign div_x   = (div_n >>> DIV_SHIFT) + ACC_W'(DIV_OFFSET);

    assign quo   = rsp.prod[RECIP_SHIFT +: QUO_W];
    assign q_s   = $signed({1'b0, quo}) - (QUO_W+1)'(1 << DIV_SHIFT);
    assign q_sat = (q_s > (QUO_W+1)'(32767))  ? coord_t'(16'sh7FFF) :
                   (q_s < -(QUO_W+1)'(32768)) ? coord_t'(16'sh8000) :
                   q_s[COORD_WIDTH-1:0];

    always_comb
    begin
        req.a   = '0;
        req.b   = '0;
        req.tag = TAG_NONE;
        unique case (state_reg)
            S_UU:
            begin
                req.a   = {5'b0, u_c};
                req.b   = {5'b0, u_c};
                req.tag = TAG_U2;
            end
            S_TT:
            begin
                req.a   = {5'b0, t_c};
                req.b   = {5'b0, t_c};
                req.tag = TAG_T2;
            end
            S_U3:
            begin
                req.a   = {5'b0, u2_reg};
                req.b   = {5'b0, u_c};
                req.tag = TAG_U3;
            end
            S_T3:
            begin
                req.a   = {5'b0, t2_reg};
                req.b   = {5'b0, t_c};
                req.tag = TAG_T3;
            end
            S_MAC:
            begin
                req.a   = {2'b0, w_reg[j_reg[1:0]]};
                req.b   = {{(MUL_W-COORD_WIDTH){csel[COORD_WIDTH-1]}}, csel};
                req.tag = j_reg[2] ? TAG_ACCY : TAG_ACCX;
            end
            S_DX, S_DY:
            begin
                req.a   = div_x[MUL_W-1:0];
                req.b   = MUL_W'(RECIP);
                req.tag = (state_reg == S_DX) ? TAG_QX : TAG_NONE;
            end
            default:
            begin
                req.tag = TAG_NONE;
            end
        endcase
    end

    assign last = {1'b0, k_reg} == n_seg - SEG_CNT_W'(1);
    assign busy = state_reg != S_IDLE;
    assign emit = (state_reg == S_EMIT) && !first_reg && slot_free;
    assign done = emit && last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_UU;
            S_UU:   state_next = S_TT;
            S_TT:   state_next = S_U3;
            S_U3:   state_next = S_T3;
            S_T3:   state_next = S_WB;
            S_WB:   state_next = S_WGT;
            S_WGT:  state_next = S_MAC;
            S_MAC:  if (j_reg == 3'd7) state_next = S_DX;
            S_DX:   state_next = S_DY;
            S_DY:   state_next = S_FIN;
            S_FIN:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (first_reg)
                begin
                    state_next = S_UU;
                end
                else if (slot_free)
                begin
                    state_next = last ? S_IDLE : S_UU;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (rsp.tag)
            TAG_U2:   u2_reg   <= pow_val;
            TAG_T2:   t2_reg   <= pow_val;
            TAG_U3:   u3_reg   <= pow_val;
            TAG_T3:   t3_reg   <= pow_val;
            TAG_ACCX: accx_reg <= accx_reg + rsp.prod[ACC_W-1:0];
            TAG_ACCY: accy_reg <= accy_reg + rsp.prod[ACC_W-1:0];
            TAG_QX:   cur_reg.x <= q_sat;
            TAG_NONE:
            begin
                if (state_reg == S_FIN)
                begin
                    cur_reg.y <= q_sat;
                end
            end
        endcase

        if (state_reg == S_IDLE && start)
        begin
            p4_reg    <= p_new;
            u_reg     <= '0;
            k_reg     <= '0;
            first_reg <= 1'b1;
        end

        if (state_reg == S_WGT)
        begin
            w_reg[0] <= {3'b0, t3_reg};
            w_reg[1] <= w2_full[WGT_W-1:0];
            w_reg[2] <= w3_full[WGT_W-1:0];
            w_reg[3] <= {3'b0, u3_reg};
            accx_reg <= '0;
            accy_reg <= '0;
            j_reg    <= '0;
        end
        else if (state_reg == S_MAC)
        begin
            j_reg <= j_reg + 3'd1;
        end

        if (state_reg == S_EMIT)
        begin
            if (first_reg)
            begin
                prev_reg  <= cur_reg;
                first_reg <= 1'b0;
                u_reg     <= u_reg + U_ACC_W'(step);
            end
            else if (slot_free)
            begin
                prev_reg <= cur_reg;
                k_reg    <= k_reg + K_W'(1);
                u_reg    <= u_reg + U_ACC_W'(step);
            end
        end
    end

    assign seg.seg_start_x = prev_reg.x;
    assign seg.seg_start_y = prev_reg.y;
    assign seg.seg_end_x   = cur_reg.x;
    assign seg.seg_end_y   = cur_reg.y;
    assign seg.span_last   = last;
    assign p4              = p4_reg;

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !first_reg) |-> {1'b0, k_reg} < n_seg)
        else $error("segment index past span length");

    a_idle_no_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (rsp.tag == TAG_NONE))
        else $error("multiplier result while idle");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the B-spline segment tessellator.
`timescale 1ns / 100ps

module tb_top import bst_pkg::*; ();

    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 700;
    localparam int STALL_LIMIT  = 6000;
    localparam int TOTAL_POINTS = 420;
    localparam int IDLE_PCT     = 36;

    localparam longint SIX_Q16   = 6 * Q_ONE;
    localparam longint COORD_HI  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO  = -COORD_HI - 1;
    localparam coord_t COORD_MAX = coord_t'(COORD_HI);
    localparam coord_t COORD_MIN = coord_t'(COORD_LO);
    localparam int     STEP_MAX  = (1 << STEP_W) - 1;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   curve_start;
    } ctrl_pt_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bst_in_if  pt_if ();
    bst_out_if seg_if ();

    bspline_segment_tessellator uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt       (pt_if),
        .seg      (seg_if),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    ctrl_pt_t              pend_pts[$];
    ctrl_pt_t              cur_pt;
    seg_t                  seg_expect[$];

    logic [SEG_CNT_W-1:0]  seg_count_reg;
    logic [STEP_W-1:0]     step_reg;
    longint                win_x[3];
    longint                win_y[3];
    int                    win_cnt = 0;

    int                    errors = 0;
    int                    send_idle_pct = IDLE_PCT;
    int                    recv_idle_pct = IDLE_PCT;
    bit                    hold_armed = 1'b0;
    bit                    hold_done;
    int                    hold_left;
    int                    stall_cycles = 0;
    int                    pts_queued = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Divide by 6*2^16 with round half up, then clamp to the coordinate range.
    function automatic coord_t scale_sat(input longint acc);
        longint num;
        longint quo;
        num = acc + HALF6;
        quo = num / SIX_Q16;
        if (num < 0 && (num % SIX_Q16) != 0)
            quo = quo - 1;
        if (quo > COORD_HI)
            quo = COORD_HI;
        else if (quo < COORD_LO)
            quo = COORD_LO;
        return coord_t'(quo);
    endfunction

    function automatic void curve_at(input longint u_raw, input longint px, input longint py,
                                     output coord_t cx, output coord_t cy);
        longint u;
        longint t;
        longint u2;
        longint u3;
        longint t2;
        longint t3;
        longint w0;
        longint w1;
        longint w2;
        longint w3;
        u  = (u_raw > Q_ONE) ? Q_ONE : u_raw;
        t  = Q_ONE - u;
        u2 = (u * u + HALF_Q16) >> 16;
        u3 = (u2 * u + HALF_Q16) >> 16;
        t2 = (t * t + HALF_Q16) >> 16;
        t3 = (t2 * t + HALF_Q16) >> 16;
        w0 = t3;
        w1 = 3 * u3 - 6 * u2 + 4 * Q_ONE;
        w2 = -3 * u3 + 3 * u2 + 3 * u + Q_ONE;
        w3 = u3;
        cx = scale_sat(w0 * win_x[0] + w1 * win_x[1] + w2 * win_x[2] + w3 * px);
        cy = scale_sat(w0 * win_y[0] + w1 * win_y[1] + w2 * win_y[2] + w3 * py);
    endfunction

    // Update the point window; queue the segments a closed span produces.
    function automatic void tessellate_point(input ctrl_pt_t p);
        longint px;
        longint py;
        longint n;
        longint k;
        longint step;
        seg_t   s;
        px   = longint'($signed(p.x));
        py   = longint'($signed(p.y));
        step = longint'(step_reg);
        if (p.curve_start)
        begin
            win_x[0] = px;
            win_y[0] = py;
            win_cnt  = 1;
            return;
        end
        if (win_cnt < 3)
        begin
            win_x[win_cnt] = px;
            win_y[win_cnt] = py;
            win_cnt++;
            return;
        end
        n = longint'(seg_count_reg);
        if (n == 0)
            n = 1;
        if (n > MAX_SEGMENTS)
            n = MAX_SEGMENTS;
        for (k = 0; k < n; k++)
        begin
            curve_at(k * step, px, py, s.seg_start_x, s.seg_start_y);
            curve_at((k + 1) * step, px, py, s.seg_end_x, s.seg_end_y);
            s.span_last = (k == n - 1);
            seg_expect.push_back(s);
        end
        win_x[0] = win_x[1];
        win_y[0] = win_y[1];
        win_x[1] = win_x[2];
        win_y[1] = win_y[2];
        win_x[2] = px;
        win_y[2] = py;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        $display("%0t: ERROR %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input longint got, input longint want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_segment();
        seg_t want;
        if (seg_expect.size() == 0)
        begin
            report_error($sformatf("unexpected segment (%0d,%0d)-(%0d,%0d)",
                                   seg_if.seg_start_x, seg_if.seg_start_y,
                                   seg_if.seg_end_x, seg_if.seg_end_y));
            return;
        end
        want = seg_expect.pop_front();
        cmp_field("seg_start_x", longint'(seg_if.seg_start_x), longint'(want.seg_start_x));
        cmp_field("seg_start_y", longint'(seg_if.seg_start_y), longint'(want.seg_start_y));
        cmp_field("seg_end_x", longint'(seg_if.seg_end_x), longint'(want.seg_end_x));
        cmp_field("seg_end_y", longint'(seg_if.seg_end_y), longint'(want.seg_end_y));
        cmp_field("span_last", longint'(seg_if.span_last), longint'(want.span_last));
    endtask

    // Control point driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_if.valid       <= 1'b0;
            pt_if.ctrl_x      <= '0;
            pt_if.ctrl_y      <= '0;
            pt_if.curve_start <= 1'b0;
        end
        else
        begin
            if (pt_if.valid && pt_if.ready)
                tessellate_point(cur_pt);
            if (!pt_if.valid || pt_if.ready)
            begin
                if (pend_pts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_pt             = pend_pts.pop_front();
                    pt_if.valid       <= 1'b1;
                    pt_if.ctrl_x      <= cur_pt.x;
                    pt_if.ctrl_y      <= cur_pt.y;
                    pt_if.curve_start <= cur_pt.curve_start;
                end
                else
                begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // Segment monitor with random back-pressure and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_if.ready <= 1'b0;
            hold_left     = 0;
            hold_done     = 1'b0;
        end
        else
        begin
            if (seg_if.valid && seg_if.ready)
                check_segment();
            if (hold_armed && !hold_done && seg_if.valid)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                seg_if.ready <= 1'b0;
            end
            else
            begin
                seg_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pt_if.valid && pt_if.ready) || (seg_if.valid && seg_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            1, 2, 3: return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    task automatic add_point(input coord_t x, input coord_t y, input logic cs);
        ctrl_pt_t p;
        p.x           = x;
        p.y           = y;
        p.curve_start = cs;
        pend_pts.push_back(p);
        pts_queued++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pend_pts.size() != 0 || pt_if.valid || seg_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] seg_val,
                             input logic [CFG_DATA_W-1:0] step_val,
                             input int count, input int sidle, input int ridle,
                             input bit pressure);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SEGMENTS;
        cfg_data <= seg_val;
        @(posedge clk);
        cfg_idx  <= REG_STEP;
        cfg_data <= step_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seg_count_reg = seg_val[SEG_CNT_W-1:0];
        step_reg      = step_val[STEP_W-1:0];
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        hold_armed    = pressure;
        repeat (count)
            add_point(random_coord(), random_coord(), ($urandom_range(0, 11) == 0));
        wait_idle();
    endtask

    initial
    begin
        int segs;
        int step;
        int pick;
        logic [CFG_DATA_W-1:0] seg_val;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = REG_SEGMENTS;
        cfg_data          = '0;
        seg_count_reg     = SEG_RESET;
        step_reg          = STEP_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: 50 segments of 1311 overshoot 1.0, so u clamps.
        add_point(16'sd100, -16'sd100, 1'b1);
        add_point(COORD_MAX, COORD_MIN, 1'b0);
        add_point(COORD_MIN, COORD_MAX, 1'b0);
        add_point(COORD_MAX, COORD_MAX, 1'b0);
        add_point(COORD_MAX, COORD_MAX, 1'b0);
        add_point(COORD_MAX, COORD_MAX, 1'b0);
        add_point(COORD_MIN, COORD_MIN, 1'b0);
        add_point(COORD_MIN, COORD_MIN, 1'b0);
        add_point(COORD_MIN, COORD_MIN, 1'b0);
        // restart while a span is ready, then again with only two points held
        add_point(16'sd0, 16'sd0, 1'b1);
        add_point(16'sd16, -16'sd16, 1'b0);
        add_point(16'sd1, 16'sd1, 1'b1);
        add_point(-16'sd1, -16'sd1, 1'b0);
        add_point(16'sd2, -16'sd2, 1'b0);
        add_point(16'sd0, 16'sd0, 1'b0);
        add_point(16'sd1000, -16'sd1000, 1'b0);
        add_point(-16'sd1, 16'sd0, 1'b0);
        wait_idle();

        // count zero read as one, count 127 capped at 64, step zero, step extremes
        run_phase(16'h0080, 16'hFFFF, 30, IDLE_PCT, IDLE_PCT, 1'b0);
        run_phase(16'h007F, 16'd1024, 6, IDLE_PCT, IDLE_PCT, 1'b0);
        run_phase(16'd64, 16'd0, 5, IDLE_PCT, IDLE_PCT, 1'b0);
        run_phase(16'd1, 16'd1, 20, IDLE_PCT, IDLE_PCT, 1'b0);
        run_phase(16'd16, 16'd4096, 25, 0, 0, 1'b1);
        run_phase(16'd8, 16'd8192, 40, 0, 0, 1'b0);

        while (pts_queued < TOTAL_POINTS)
        begin
            pick = $urandom_range(0, 9);
            segs = (pick == 3) ? $urandom_range(60, 127) : $urandom_range(1, 10);
            step = Q_ONE / ((segs > MAX_SEGMENTS) ? MAX_SEGMENTS : segs);
            if (pick == 0)
                step = $urandom_range(0, STEP_MAX);
            else if (pick == 1)
                step = step + $urandom_range(0, 4096);
            if (step > STEP_MAX)
                step = STEP_MAX;
            seg_val = CFG_DATA_W'(segs);
            if (pick == 2)
                seg_val[CFG_DATA_W-1:SEG_CNT_W] = (CFG_DATA_W-SEG_CNT_W)'($urandom);
            run_phase(seg_val, CFG_DATA_W'(step), 40, IDLE_PCT, IDLE_PCT, 1'b0);
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
